@@ rtl/lla_pkg.sv @@
// lla_pkg: shared types and constants of the light level averager.
// No dependencies; imported by light_level_averager_unit.
package lla_pkg;

   // field widths
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned MV_W     = 12;
   localparam int unsigned PCT_W    = 14;
   localparam int unsigned LEVEL_W  = 3;
   localparam int unsigned PADDR_W  = 4;
   localparam int unsigned PDATA_W  = 32;

   // shared divider: quotient bits per operation
   localparam int unsigned QUO_W     = 14;
   localparam int unsigned AVG_QBITS = 12;
   localparam int unsigned PCT_QBITS = 14;
   localparam int unsigned STEP_W    = 4;

   // shared multiplier operand widths
   localparam int unsigned MUL_A_W = 12;
   localparam int unsigned MUL_B_W = 14;
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
   localparam logic [1:0] REG_MIN_RAW      = 2'd1;
   localparam logic [1:0] REG_MAX_RAW      = 2'd2;

   // reset values
   localparam logic [COUNT_W-1:0]  RST_SAMPLE_COUNT = 11'd16;
   localparam logic [SAMPLE_W-1:0] RST_MIN_RAW      = 12'd100;
   localparam logic [SAMPLE_W-1:0] RST_MAX_RAW      = 12'd4095;

   // voltage curve
   localparam logic [SAMPLE_W-1:0] VOLT_KNEE      = 12'd2048;
   localparam logic [MUL_B_W-1:0]  VOLT_LOW_GAIN  = 14'd1100;
   localparam logic [MUL_B_W-1:0]  VOLT_HIGH_GAIN = 14'd1350;
   localparam logic [MV_W-1:0]     VOLT_KNEE_MV   = 12'd1100;
   localparam logic [MV_W-1:0]     VOLT_HIGH_SPAN = 12'd2047;

   // percent scale and level thresholds
   localparam logic [MUL_B_W-1:0] PCT_SCALE = 14'd10000;
   localparam logic [PCT_W-1:0]   PCT_FULL  = 14'd10000;
   localparam logic [PCT_W-1:0]   PCT_ZERO  = 14'd0;
   localparam logic [PCT_W-1:0]   LVL_DIM_TH    = 14'd1000;
   localparam logic [PCT_W-1:0]   LVL_SHADOW_TH = 14'd3000;
   localparam logic [PCT_W-1:0]   LVL_BRIGHT_TH = 14'd6000;
   localparam logic [PCT_W-1:0]   LVL_VBRIGHT_TH = 14'd8500;

   localparam logic [LEVEL_W-1:0] LVL_DARK    = 3'd0;
   localparam logic [LEVEL_W-1:0] LVL_DIM     = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_SHADOW  = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_BRIGHT  = 3'd3;
   localparam logic [LEVEL_W-1:0] LVL_VBRIGHT = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_AVG,
      ST_MUL_V,
      ST_VOLT,
      ST_MUL_P,
      ST_LOAD_P,
      ST_DIV_P,
      ST_DONE
   } lla_state_type;

   function automatic logic [LEVEL_W-1:0] level_of(input logic [PCT_W-1:0] pct);
      logic [LEVEL_W-1:0] lvl;
      if (pct < LVL_DIM_TH)          lvl = LVL_DARK;
      else if (pct < LVL_SHADOW_TH)  lvl = LVL_DIM;
      else if (pct < LVL_BRIGHT_TH)  lvl = LVL_SHADOW;
      else if (pct < LVL_VBRIGHT_TH) lvl = LVL_BRIGHT;
      else                           lvl = LVL_VBRIGHT;
      return lvl;
   endfunction

endpackage

@@ rtl/light_level_averager_unit.sv @@
// light_level_averager_unit: boxcar average of ADC samples with voltage and
// percent calibration. Depends on lla_pkg (types, constants, level_of).
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   request  | req_valid/req_stall  | req_adc_sample
//   response | rsp_valid/rsp_stall  | rsp_average_raw, rsp_voltage_mv,
//            |                      | rsp_percent_hundredths, rsp_light_level
//   config   | APB psel/penable     | paddr, pwdata, prdata (pready tied high)
//
// A request that does not close a window is only accumulated. A request
// that closes it runs the shared restoring divider (one bit per cycle) and
// the shared 12x14 multiplier: 12 average bits, then, unless the percent
// clamps, 14 percent bits. Synchronous active-high reset clears the window
// and loads register defaults. A finished response waits in the output
// register; the next request is taken meanwhile, and only a second closed
// window waits for it to drain.
module light_level_averager_unit #(
   parameter int unsigned MAX_SAMPLES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lla_pkg::SAMPLE_W-1:0]  req_adc_sample,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lla_pkg::SAMPLE_W-1:0]  rsp_average_raw,
   output logic [lla_pkg::MV_W-1:0]      rsp_voltage_mv,
   output logic [lla_pkg::PCT_W-1:0]     rsp_percent_hundredths,
   output logic [lla_pkg::LEVEL_W-1:0]   rsp_light_level,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lla_pkg::PADDR_W-1:0]   paddr,
   input  logic [lla_pkg::PDATA_W-1:0]   pwdata,
   output logic [lla_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import lla_pkg::*;

   // window counter, sum, divider widths
   localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned SW = CW + SAMPLE_W;
   localparam int unsigned EW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int unsigned DW = (CW > SAMPLE_W) ? CW : SAMPLE_W;
   localparam logic [EW-1:0] MAX_CNT = EW'(MAX_SAMPLES);

   lla_state_type state_ff, state_in;

   // configuration registers
   logic [COUNT_W-1:0]  cfg_count_ff;
   logic [SAMPLE_W-1:0] cfg_min_ff, cfg_max_ff;

   // window state
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] seen_ff, seen_in;

   // shared divider
   logic [DW-1:0]     div_rem_ff, div_rem_in;
   logic [DW-1:0]     div_den_ff, div_den_in;
   logic [QUO_W-1:0]  div_sh_ff, div_sh_in;
   logic [QUO_W-1:0]  div_q_ff, div_q_in;
   logic [STEP_W-1:0] div_cnt_ff, div_cnt_in;
   logic [DW:0]       div_trial;
   logic              div_ge;
   logic              div_last;

   // shared multiplier
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // result registers
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [MV_W-1:0]     volt_ff, volt_in;
   logic [PCT_W-1:0]    pct_ff, pct_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] out_avg_ff, out_avg_in;
   logic [MV_W-1:0]     out_volt_ff, out_volt_in;
   logic [PCT_W-1:0]    out_pct_ff, out_pct_in;
   logic [LEVEL_W-1:0]  out_lvl_ff, out_lvl_in;

   // request side
   logic          req_take;
   logic [SW-1:0] sum_next;
   logic [CW-1:0] seen_next;
   logic [EW-1:0] eff_count;
   logic          win_close;

   // voltage helpers
   logic [10:0]     vh_q0;
   logic [MV_W-1:0] vh_r0;
   logic [10:0]     vh_q;

   logic cfg_wr;

   //---------------------------------------------------------------
   // configuration port
   //---------------------------------------------------------------
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_count_ff <= RST_SAMPLE_COUNT;
         cfg_min_ff   <= RST_MIN_RAW;
         cfg_max_ff   <= RST_MAX_RAW;
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            REG_SAMPLE_COUNT: cfg_count_ff <= pwdata[COUNT_W-1:0];
            REG_MIN_RAW:      cfg_min_ff   <= pwdata[SAMPLE_W-1:0];
            REG_MAX_RAW:      cfg_max_ff   <= pwdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_SAMPLE_COUNT: prdata = PDATA_W'(cfg_count_ff);
         REG_MIN_RAW:      prdata = PDATA_W'(cfg_min_ff);
         REG_MAX_RAW:      prdata = PDATA_W'(cfg_max_ff);
         default:          prdata = '0;
      endcase
   end

   //---------------------------------------------------------------
   // window accumulation
   //---------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;

   // zero count acts as one, large counts clamp to MAX_SAMPLES
   always_comb begin
      if (cfg_count_ff == '0)
         eff_count = EW'(1);
      else if (EW'(cfg_count_ff) > MAX_CNT)
         eff_count = MAX_CNT;
      else
         eff_count = EW'(cfg_count_ff);
   end

   assign sum_next  = sum_ff + SW'(req_adc_sample);
   assign seen_next = seen_ff + CW'(1);
   // lowered count mid-window closes on the next sample
   assign win_close = (EW'(seen_next) >= eff_count);

   //---------------------------------------------------------------
   // shared divider step: restoring, one quotient bit per cycle
   //---------------------------------------------------------------
   assign div_trial = {div_rem_ff, div_sh_ff[QUO_W-1]};
   assign div_ge    = (div_trial >= {1'b0, div_den_ff});
   assign div_last  = (div_cnt_ff == STEP_W'(1));

   //---------------------------------------------------------------
   // voltage above the knee: x / 2047 via x/2048 plus one correction
   //---------------------------------------------------------------
   assign vh_q0 = prod_ff[21:11];
   assign vh_r0 = MV_W'(prod_ff[10:0]) + MV_W'(vh_q0);
   assign vh_q  = vh_q0 + 11'(vh_r0 >= VOLT_HIGH_SPAN);

   // shared multiplier operands
   always_comb begin
      mul_a = MUL_A_W'(avg_ff - cfg_min_ff);
      mul_b = PCT_SCALE;
      if (state_ff == ST_MUL_V) begin
         if (div_q_ff[SAMPLE_W-1:0] < VOLT_KNEE) begin
            mul_a = div_q_ff[SAMPLE_W-1:0];
            mul_b = VOLT_LOW_GAIN;
         end else begin
            mul_a = div_q_ff[SAMPLE_W-1:0] - VOLT_KNEE;
            mul_b = VOLT_HIGH_GAIN;
         end
      end
   end

   //---------------------------------------------------------------
   // sequencer
   //---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_sh_ff   <= div_sh_in;
      div_q_ff    <= div_q_in;
      div_cnt_ff  <= div_cnt_in;
      prod_ff     <= prod_in;
      avg_ff      <= avg_in;
      volt_ff     <= volt_in;
      pct_ff      <= pct_in;
      out_avg_ff  <= out_avg_in;
      out_volt_ff <= out_volt_in;
      out_pct_ff  <= out_pct_in;
      out_lvl_ff  <= out_lvl_in;
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      seen_in      = seen_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_sh_in    = div_sh_ff;
      div_q_in     = div_q_ff;
      div_cnt_in   = div_cnt_ff;
      prod_in      = prod_ff;
      avg_in       = avg_ff;
      volt_in      = volt_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      out_avg_in   = out_avg_ff;
      out_volt_in  = out_volt_ff;
      out_pct_in   = out_pct_ff;
      out_lvl_in   = out_lvl_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (win_close) begin
                  sum_in     = '0;
                  seen_in    = '0;
                  // sum < count * 4096, so the top bits already sit below the divisor
                  div_rem_in = DW'(sum_next >> AVG_QBITS);
                  div_sh_in  = QUO_W'(sum_next[AVG_QBITS-1:0]) << (QUO_W - AVG_QBITS);
                  div_den_in = DW'(seen_next);
                  div_q_in   = '0;
                  div_cnt_in = STEP_W'(AVG_QBITS);
                  state_in   = ST_DIV_AVG;
               end else begin
                  sum_in  = sum_next;
                  seen_in = seen_next;
               end
            end
         end
         ST_DIV_AVG, ST_DIV_P: begin
            div_rem_in = div_ge ? DW'(div_trial - {1'b0, div_den_ff}) : DW'(div_trial);
            div_sh_in  = div_sh_ff << 1;
            div_q_in   = {div_q_ff[QUO_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff - STEP_W'(1);
            if (div_last) begin
               if (state_ff == ST_DIV_AVG) begin
                  state_in = ST_MUL_V;
               end else begin
                  pct_in   = PCT_W'({div_q_ff[QUO_W-2:0], div_ge});
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL_V: begin
            avg_in   = div_q_ff[SAMPLE_W-1:0];
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_VOLT;
         end
         ST_VOLT: begin
            if (avg_ff < VOLT_KNEE)
               volt_in = MV_W'(prod_ff[21:11]);
            else
               volt_in = VOLT_KNEE_MV + MV_W'(vh_q);
            // min test first: inverted calibration never divides
            if (avg_ff <= cfg_min_ff) begin
               pct_in   = PCT_ZERO;
               state_in = ST_DONE;
            end else if (avg_ff >= cfg_max_ff) begin
               pct_in   = PCT_FULL;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_LOAD_P;
         end
         ST_LOAD_P: begin
            // quotient < 10000 keeps numerator >> 14 below the divisor
            div_rem_in = DW'(prod_ff >> PCT_QBITS);
            div_sh_in  = prod_ff[PCT_QBITS-1:0];
            div_den_in = DW'(cfg_max_ff - cfg_min_ff);
            div_q_in   = '0;
            div_cnt_in = STEP_W'(PCT_QBITS);
            state_in   = ST_DIV_P;
         end
         ST_DONE: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_avg_in   = avg_ff;
               out_volt_in  = volt_ff;
               out_pct_in   = pct_ff;
               out_lvl_in   = level_of(pct_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_average_raw        = out_avg_ff;
   assign rsp_voltage_mv         = out_volt_ff;
   assign rsp_percent_hundredths = out_pct_ff;
   assign rsp_light_level        = out_lvl_ff;

endmodule
